// ===== rtl/swmd_pkg.sv =====
package swmd_pkg;

	// Stack geometry
	localparam int DEPTH   = 128;
	localparam int ADDR_W  = $clog2(DEPTH);
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int WORD_W  = 32;
	localparam int FILL_W  = 8;

	// Request queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		REQ_PUSH    = 2'd0,
		REQ_POP     = 2'd1,
		REQ_DEL_MID = 2'd2,
		REQ_NOP     = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_UNDERFLOW = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_POP_WAIT,
		BK_DEL_WAIT,
		BK_SHIFT
	} back_state_t;

	typedef struct packed {
		req_t              req;
		logic [WORD_W-1:0] value;
	} req_item_t;

	// Queue head as seen by the back part
	typedef struct packed {
		logic      valid;
		req_item_t item;
	} queue_head_t;

	localparam logic [WORD_W-1:0] NEG_ONE = '1;

endpackage

// ===== rtl/swmd_front.sv =====
module swmd_front
	import swmd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        in_req,
	input  logic [WORD_W-1:0] in_value,
	output queue_head_t       head,
	input  logic              head_pop
);

	req_item_t         slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              push;
	logic              pop;
	req_item_t         item_in;

	// Classify the request code into its kind
	always_comb begin
		item_in.value = in_value;
		case (in_req)
			REQ_PUSH:    item_in.req = REQ_PUSH;
			REQ_POP:     item_in.req = REQ_POP;
			REQ_DEL_MID: item_in.req = REQ_DEL_MID;
			default:     item_in.req = REQ_NOP;
		endcase
	end

	assign in_ready   = (cnt_q != QCNT_W'(QUEUE_DEPTH));
	assign push       = in_valid && in_ready;
	assign head.valid = (cnt_q != '0);
	assign head.item  = slot_q[rd_ptr_q];
	assign pop        = head_pop && head.valid;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== rtl/swmd_back.sv =====
module swmd_back
	import swmd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  queue_head_t       head,
	output logic              head_pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [WORD_W-1:0] out_value,
	output logic [1:0]        out_status,
	output logic [FILL_W-1:0] out_fill
);

	logic [WORD_W-1:0] mem [DEPTH];
	logic [WORD_W-1:0] rd_data_q;

	back_state_t       state_q, state_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	logic [CNT_W-1:0]  idx_q, idx_d;
	logic [WORD_W-1:0] res_q, res_d;

	logic              out_vld_q;
	logic [WORD_W-1:0] out_value_q;
	status_t           out_status_q;
	logic [FILL_W-1:0] out_fill_q;

	logic              out_load;
	logic [WORD_W-1:0] load_value;
	status_t           load_status;

	logic              mem_we;
	logic [CNT_W-1:0]  wr_idx;
	logic [WORD_W-1:0] wr_data;
	logic [CNT_W-1:0]  rd_idx;
	logic [CNT_W-1:0]  mid;
	logic              out_free;

	assign out_free = !out_vld_q || out_ready;
	assign mid      = cnt_q >> 1;

	always_comb begin
		state_d     = state_q;
		cnt_d       = cnt_q;
		idx_d       = idx_q;
		res_d       = res_q;
		head_pop    = 1'b0;
		out_load    = 1'b0;
		load_value  = '0;
		load_status = ST_OK;
		mem_we      = 1'b0;
		wr_idx      = cnt_q;
		wr_data     = head.item.value;
		rd_idx      = '0;
		case (state_q)
			BK_IDLE: begin
				if (head.valid && out_free) begin
					head_pop = 1'b1;
					case (head.item.req)
						REQ_PUSH: begin
							out_load = 1'b1;
							if (cnt_q >= CNT_W'(DEPTH)) begin
								load_status = ST_OVERFLOW;
							end else begin
								mem_we = 1'b1;
								cnt_d  = cnt_q + 1'b1;
							end
						end
						REQ_POP: begin
							if (cnt_q == '0) begin
								out_load    = 1'b1;
								load_value  = NEG_ONE;
								load_status = ST_UNDERFLOW;
							end else begin
								cnt_d   = cnt_q - 1'b1;
								rd_idx  = cnt_q - 1'b1;
								state_d = BK_POP_WAIT;
							end
						end
						REQ_DEL_MID: begin
							if (cnt_q == '0) begin
								out_load    = 1'b1;
								load_value  = NEG_ONE;
								load_status = ST_UNDERFLOW;
							end else begin
								cnt_d   = cnt_q - 1'b1;
								rd_idx  = mid;
								idx_d   = mid;
								state_d = BK_DEL_WAIT;
							end
						end
						default: begin
							out_load = 1'b1;
						end
					endcase
				end
			end
			BK_POP_WAIT: begin
				out_load   = 1'b1;
				load_value = rd_data_q;
				state_d    = BK_IDLE;
			end
			BK_DEL_WAIT: begin
				// cnt_q already holds the count after removal
				if (idx_q < cnt_q) begin
					res_d   = rd_data_q;
					rd_idx  = idx_q + 1'b1;
					state_d = BK_SHIFT;
				end else begin
					out_load   = 1'b1;
					load_value = rd_data_q;
					state_d    = BK_IDLE;
				end
			end
			BK_SHIFT: begin
				// rd_data_q holds the word above idx_q: move it down one place
				mem_we  = 1'b1;
				wr_idx  = idx_q;
				wr_data = rd_data_q;
				if ((idx_q + 1'b1) < cnt_q) begin
					rd_idx = idx_q + CNT_W'(2);
					idx_d  = idx_q + 1'b1;
				end else begin
					out_load   = 1'b1;
					load_value = res_q;
					state_d    = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_idx[ADDR_W-1:0]] <= wr_data;
		end
		rd_data_q <= mem[rd_idx[ADDR_W-1:0]];
	end

	always_ff @(posedge clk) begin
		idx_q <= idx_d;
		res_q <= res_d;
		if (out_load) begin
			out_value_q  <= load_value;
			out_status_q <= load_status;
			out_fill_q   <= FILL_W'(cnt_d);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= BK_IDLE;
			cnt_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign out_valid  = out_vld_q;
	assign out_value  = out_value_q;
	assign out_status = out_status_q;
	assign out_fill   = out_fill_q;

endmodule

// ===== rtl/stack_with_middle_delete_top.sv =====
// Channel   | Dir | Signals                          | Contents (lowest bit first)
// ----------+-----+----------------------------------+------------------------------------
// s_axis    | in  | tvalid, tready, tdata[31:0],     | tdata: push_value[31:0]
//           |     | tuser[1:0]                       | tuser: req_type[1:0]
// m_axis    | out | tvalid, tready, tdata[39:0],     | tdata: out_value[31:0], fill_count[39:32]
//           |     | tuser[1:0]                       | tuser: status[1:0]
//
// Push, overflowing push, empty pop/delete and the unused code finish straight from the idle
// state; pop waits on one registered memory read. Delete-middle reads the middle word, then
// moves each word above it down one place, one word move per cycle, through the single-write, single-read word memory.
// arst_n clears the count, the queue and the result valid flag; the word memory needs no clear.
// A two-entry request queue lets the input keep taking transfers, until full, while the back end
// shifts or while a result waits on m_axis_tready; the result register holds until taken.
module stack_with_middle_delete_top
	import swmd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // push_value[31:0]
	input  logic [1:0]  s_axis_tuser,  // req_type[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // out_value[31:0], fill_count[39:32]
	output logic [1:0]  m_axis_tuser   // status[1:0]
);

	queue_head_t       head;
	logic              head_pop;
	logic [WORD_W-1:0] res_value;
	logic [FILL_W-1:0] res_fill;

	// Front: take request transfers, decode the code, buffer them
	swmd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_req   (s_axis_tuser),
		.in_value (s_axis_tdata),
		.head     (head),
		.head_pop (head_pop)
	);

	// Back: run each request against the word memory and hold its result
	swmd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_pop   (head_pop),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_value  (res_value),
		.out_status (m_axis_tuser),
		.out_fill   (res_fill)
	);

	// Pack the result: value low, fill count in the top byte
	assign m_axis_tdata = {res_fill, res_value};

endmodule
